>>> design/mma_pkg.sv
// Shared types, constants and helpers of the multichannel moving average unit.
`timescale 1ns / 1ps

package mma_pkg;

    // Window length per channel; the mean is taken by a shift, so keep it a power of two
    localparam int WINDOW      = 256;
    localparam int CHANNELS    = 32;
    localparam int SAMPLE_BITS = 16;

    // Channel number width is fixed by the stream format
    localparam int CH_BITS    = 5;
    localparam int POS_BITS   = $clog2(WINDOW);
    localparam int SUM_BITS   = SAMPLE_BITS + POS_BITS;
    localparam int ADDR_BITS  = CH_BITS + POS_BITS;
    localparam int SAMP_DEPTH = CHANNELS * (2 ** POS_BITS);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic        [CH_BITS-1:0]     chan_t;
    typedef logic        [POS_BITS-1:0]    pos_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;

    // Per-channel bookkeeping held in the channel RAM
    typedef struct packed {
        logic wrapped;  // window has been filled once: stored samples are live
        pos_t pos;      // next slot to overwrite
        sum_t sum;      // running window sum
    } chan_state_t;

    localparam int STATE_BITS = $bits(chan_state_t);

    // Advance a write position cyclically through the window
    function automatic pos_t next_pos(input pos_t p);
        pos_t r;
        if (p == pos_t'(WINDOW - 1)) begin
            r = '0;
        end else begin
            r = p + pos_t'(1);
        end
        return r;
    endfunction

    // Window sum divided by the window length, truncated toward zero
    function automatic sample_t window_mean(input sum_t s);
        sum_t bias;
        sum_t biased;
        bias   = s[SUM_BITS-1] ? sum_t'(WINDOW - 1) : '0;
        biased = s + bias;
        return sample_t'(biased >>> POS_BITS);
    endfunction

endpackage

>>> design/mma_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
`timescale 1ns / 1ps

module mma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents on a same-address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/multichannel_moving_average_unit.sv
// Top level of the multichannel moving average unit.
//
//  Channel | Direction | tdata (low bit up) | tuser (low bit up)
//  s_      | in        | [15:0] sample      | [4:0] channel
//  m_      | out       | [15:0] average     | -
//
// One request per cycle is taken unless m_ is stalled. The result passes the
// channel RAM read, the sample RAM read-modify-write and the output register,
// the three stages, before it is presented on m_. Channel state is forwarded from
// the stage ahead and from the last write, so back-to-back requests to one
// channel need no bubble. Reset clears all control state at once: channel
// valid bits and per-channel wrap flags stand in for clearing the sample
// store, so no clearing pass is run. A stall on m_ holds the whole pipeline.
`timescale 1ns / 1ps

module multichannel_moving_average_unit
    import mma_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [4:0]  s_tuser,   // [4:0] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] average
);

    logic accept;
    logic advance;

    // Stage 1: channel state being read
    logic        v1_reg, v1_next;
    sample_t     sample1_reg;
    chan_t       ch1_reg;
    chan_state_t chan_rd;
    chan_state_t state1;

    // Stage 2: old sample being read
    logic        v2_reg, v2_next;
    sample_t     sample2_reg;
    chan_t       ch2_reg;
    chan_state_t state2_reg;
    sample_t     samp_rd;
    sample_t     old2;
    chan_state_t state2_new;

    // Channel RAM bookkeeping
    logic [CHANNELS-1:0] chan_vld_reg, chan_vld_next;
    logic                lw_valid_reg, lw_valid_next;
    chan_t               lw_ch_reg;
    chan_state_t         lw_state_reg;
    logic                chan_wr_en;

    // Output register
    logic    m_valid_reg, m_valid_next;
    sample_t average_reg;

    logic samp_en;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    // Channel state store: read on acceptance, written back when stage 2 retires
    mma_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .aclk    (aclk),
        .wr_en   (chan_wr_en),
        .wr_addr (ch2_reg),
        .wr_data (state2_new),
        .rd_en   (accept),
        .rd_addr (s_tuser),
        .rd_data (chan_rd)
    );

    // Resolve stage 1 state: stage 2 result first, then last write, then RAM
    always_comb begin
        state1 = chan_vld_reg[ch1_reg] ? chan_rd : '0;
        if (lw_valid_reg && (lw_ch_reg == ch1_reg)) begin
            state1 = lw_state_reg;
        end
        if (v2_reg && (ch2_reg == ch1_reg)) begin
            state1 = state2_new;
        end
    end

    assign samp_en = advance && v1_reg;

    // Sample store: fetch the oldest sample and drop the new one in its slot
    mma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SAMP_DEPTH)
    ) u_samp_ram (
        .aclk    (aclk),
        .wr_en   (samp_en),
        .wr_addr ({ch1_reg, state1.pos}),
        .wr_data (sample1_reg),
        .rd_en   (samp_en),
        .rd_addr ({ch1_reg, state1.pos}),
        .rd_data (samp_rd)
    );

    // Update the running sum; unwritten slots of a fresh window count as zero
    always_comb begin
        old2               = state2_reg.wrapped ? samp_rd : '0;
        state2_new.wrapped = state2_reg.wrapped || (state2_reg.pos == pos_t'(WINDOW - 1));
        state2_new.pos     = next_pos(state2_reg.pos);
        state2_new.sum     = state2_reg.sum + sum_t'(sample2_reg) - sum_t'(old2);
    end

    assign chan_wr_en = advance && v2_reg;

    // Control next values
    always_comb begin
        v1_next       = advance ? accept : v1_reg;
        v2_next       = advance ? v1_reg : v2_reg;
        m_valid_next  = advance ? v2_reg : m_valid_reg;
        chan_vld_next = chan_vld_reg;
        lw_valid_next = lw_valid_reg;
        if (chan_wr_en) begin
            chan_vld_next[ch2_reg] = 1'b1;
            lw_valid_next          = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
            chan_vld_reg <= '0;
            lw_valid_reg <= 1'b0;
        end else begin
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            m_valid_reg  <= m_valid_next;
            chan_vld_reg <= chan_vld_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample1_reg <= sample_t'(s_tdata);
            ch1_reg     <= s_tuser;
        end
        if (advance) begin
            sample2_reg <= sample1_reg;
            ch2_reg     <= ch1_reg;
            state2_reg  <= state1;
            average_reg <= window_mean(state2_new.sum);
        end
        if (chan_wr_en) begin
            lw_ch_reg    <= ch2_reg;
            lw_state_reg <= state2_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = average_reg;

    // An accepted request always enters stage 1
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted request did not reach stage 1");

    // A stalled stage 2 keeps its channel and state
    a_stage2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !advance |=> v2_reg && $stable(ch2_reg) && $stable(state2_reg))
        else $error("stage 2 changed during a stall");

    // A retiring stage 2 always presents a result
    a_stage2_result: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && advance |=> m_tvalid)
        else $error("stage 2 retired without a result");

endmodule

>>> test/multichannel_moving_average_unit_test.sv
// Self-checking testbench for the multichannel moving average unit.
`timescale 1ns / 1ps

module multichannel_moving_average_unit_test
    import mma_pkg::*;
();

    localparam int CLOCK_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 12;
    localparam int RANDOM_PER_PHASE = 150;

    // One expected average, tagged with its channel for readable messages
    typedef struct packed {
        logic [4:0]  ch;
        logic [15:0] avg;
    } average_entry_t;

    // Kinds of sample run used by the random stimulus
    typedef enum int {
        RANDOM_FULL,
        HOLD_MAX,
        HOLD_MIN,
        NEAR_ZERO
    } run_kind_t;

    // Mirror of the per-channel windows and the queue of averages still owed
    class average_scoreboard;
        int             window_store [CHANNELS][WINDOW];
        int             slot         [CHANNELS];
        int             running_sum  [CHANNELS];
        average_entry_t expected_averages [$];
        int             errors;

        function int pending();
            return expected_averages.size();
        endfunction

        // Replace the oldest sample of the channel and queue the new mean
        function void note_request(logic [15:0] smp, logic [4:0] ch);
            int             idx;
            int             s;
            average_entry_t e;
            idx = int'(ch) % CHANNELS;
            s = $signed(smp);
            running_sum[idx] += s - window_store[idx][slot[idx]];
            window_store[idx][slot[idx]] = s;
            slot[idx] = (slot[idx] + 1) % WINDOW;
            e.ch  = ch;
            e.avg = 16'(running_sum[idx] / WINDOW);
            expected_averages.push_back(e);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] error: %s", $time, what);
            errors++;
        endtask

        // Compare one accepted average against the oldest one owed
        task check_result(logic [15:0] got);
            average_entry_t e;
            if (expected_averages.size() == 0) begin
                report_mismatch($sformatf("average %h with no request outstanding", got));
            end else begin
                e = expected_averages.pop_front();
                if (got !== e.avg) begin
                    report_mismatch($sformatf("channel %0d average %h, predicted %h",
                                              e.ch, got, e.avg));
                end
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [4:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    average_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    multichannel_moving_average_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] sample
        .s_tuser  (s_tuser),   // [4:0] channel
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [15:0] average
    );

    always #4 aclk = ~aclk;

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every accepted average
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // Abort a run that exceeds the overall clock limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CLOCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input logic [15:0] smp, input logic [4:0] ch);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_request(smp, ch);
    endtask

    // Extremes, truncation toward zero for both signs and early averages
    task automatic run_directed();
        send_request(16'h7FFF, 5'd0);
        send_request(16'h7FFF, 5'd0);
        send_request(16'h8000, 5'd0);
        send_request(16'h8000, 5'd0);
        send_request(16'h0000, 5'd0);
        send_request(16'hFFFF, 5'd0);
        send_request(16'h0001, 5'd0);
        send_request(16'hFF01, 5'd5);   // -255: mean truncates to zero
        send_request(16'hFFFF, 5'd5);   // sum -256: mean -1
        send_request(16'hFFFF, 5'd5);   // sum -257: still -1
        send_request(16'h00FF, 5'd6);   // 255: mean zero
        send_request(16'h0001, 5'd6);   // 256: mean one
        send_request(16'h7FFF, 5'd31);
        send_request(16'h8000, 5'd31);
        send_request(16'h5555, 5'd16);
        send_request(16'hAAAA, 5'd15);
        send_request(16'h8000, 5'd16);
        send_request(16'h7FFF, 5'd15);
    endtask

    // Fill a whole window with one extreme value, wrapping the write position
    task automatic run_saturation(input logic [15:0] value, input logic [4:0] ch);
        int len;
        len = WINDOW + $urandom_range(0, 8);
        repeat (len) send_request(value, ch);
    endtask

    // Runs of random kind and length, mostly on a few busy channels
    task automatic run_random(input int count);
        int          sent;
        int          len;
        run_kind_t   kind;
        logic [4:0]  ch;
        logic [15:0] smp;
        sent = 0;
        while (sent < count) begin
            kind = run_kind_t'($urandom_range(0, 3));
            len  = $urandom_range(1, 40);
            if ($urandom_range(99) < 70) begin
                case ($urandom_range(0, 3))
                    0: ch = 5'd0;
                    1: ch = 5'd1;
                    2: ch = 5'd30;
                    default: ch = 5'd31;
                endcase
            end else begin
                ch = 5'($urandom_range(0, CHANNELS - 1));
            end
            repeat (len) begin
                case (kind)
                    HOLD_MAX:  smp = 16'h7FFF;
                    HOLD_MIN:  smp = 16'h8000;
                    NEAR_ZERO: smp = 16'($urandom_range(0, 511) - 256);
                    default:   smp = 16'($urandom_range(0, 65535));
                endcase
                // Scatter single requests to other channels within a run
                if ($urandom_range(99) < 10) begin
                    send_request(smp, 5'($urandom_range(0, CHANNELS - 1)));
                end else begin
                    send_request(smp, ch);
                end
                sent++;
            end
        end
    endtask

    // Hold off until every average owed has come out, then let the pipe settle
    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        sb = new;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            if (phase == 0) begin
                run_directed();
            end
            run_saturation((phase % 2 == 0) ? 16'h7FFF : 16'h8000,
                           (phase < 2) ? 5'd31 : 5'd0);
            run_random(RANDOM_PER_PHASE);
            s_tvalid <= 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> multichannel_moving_average_unit.f
design/mma_pkg.sv
design/mma_ram.sv
design/multichannel_moving_average_unit.sv
test/multichannel_moving_average_unit_test.sv
